/* sv/binary_thinning_pass_defines.svh */
// ============================================================================
// Binary thinning pass assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off while the
// synchronous reset i_rst_n is low.
// ============================================================================
`ifndef BINARY_THINNING_PASS_DEFINES_SVH
`define BINARY_THINNING_PASS_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BTHP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define BTHP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* sv/bthp_pkg.sv */
// ============================================================================
// Binary thinning pass package
// Widths, register indexes, beat types and the neighborhood flag tables
// shared by the front end, the queue, the back end and the top level.
// ============================================================================
package bthp_pkg;

    // Fixed field widths.
    localparam int PIX_W     = 8;
    localparam int TALLY_W   = 20;
    localparam int CFG_W     = 11;
    localparam int DIM_CFG_W = 11;
    localparam int CFG_IDX_W = 3;

    // Decoupling queue between front and back end.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // Smallest legal frame dimension and first interior row or column.
    localparam int DIM_MIN        = 3;
    localparam int FIRST_INTERIOR = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_COLOR     = 3'd0,
        CFG_FRAME_COLS   = 3'd1,
        CFG_FRAME_ROWS   = 3'd2,
        CFG_STAGE_SELECT = 3'd3,
        CFG_PASS_PARITY  = 3'd4
    } t_cfg_idx;

    // Table select and flag codes.
    localparam logic       STAGE_MAIN = 1'b0;
    localparam logic [1:0] FLAG_NONE  = 2'b00;
    localparam logic [1:0] FLAG_PASS0 = 2'b01;
    localparam logic [1:0] FLAG_PASS1 = 2'b10;
    localparam logic [1:0] FLAG_BOTH  = 2'b11;

    // Where a pixel sits in the frame, worked out by the front end.
    typedef struct packed {
        logic emit;   // centre is interior, a result is due
        logic last;   // centre is the last interior pixel
        logic first;  // pixel is the frame origin, tally restarts
    } t_pos;

    // One beat from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
        t_pos             pos;
    } t_front_beat;

    // Front end status seen by the top level.
    typedef struct packed {
        logic clr_busy;
        logic f1_valid;
    } t_front_stat;

    // Main thinning table; entries not listed are zero.
    function automatic logic [1:0] flag_main(input logic [7:0] idx);
        logic [1:0] flag;
        unique case (idx)
            8'd6, 8'd11, 8'd12, 8'd14, 8'd131, 8'd134, 8'd143, 8'd159,
            8'd161, 8'd194, 8'd198, 8'd207, 8'd227, 8'd231, 8'd243:
                flag = FLAG_PASS0;
            8'd26, 8'd56, 8'd62, 8'd63, 8'd96, 8'd104, 8'd108, 8'd126,
            8'd176, 8'd192, 8'd224, 8'd248, 8'd249, 8'd252:
                flag = FLAG_PASS1;
            8'd7, 8'd10, 8'd15, 8'd28, 8'd30, 8'd31, 8'd40, 8'd60,
            8'd112, 8'd120, 8'd124, 8'd130, 8'd135, 8'd160, 8'd193,
            8'd195, 8'd199, 8'd225, 8'd240, 8'd241:
                flag = FLAG_BOTH;
            default:
                flag = FLAG_NONE;
        endcase
        return flag;
    endfunction

    // Stuck-pixel cleanup table; entries not listed are zero.
    function automatic logic [1:0] flag_clean(input logic [7:0] idx);
        logic [1:0] flag;
        unique case (idx)
            8'd3, 8'd129, 8'd226:
                flag = FLAG_PASS0;
            8'd24, 8'd26, 8'd27, 8'd46, 8'd48, 8'd58, 8'd154, 8'd184:
                flag = FLAG_PASS1;
            default:
                flag = FLAG_NONE;
        endcase
        return flag;
    endfunction

    // Flag for a neighborhood index from the selected table.
    function automatic logic [1:0] flag_lookup(input logic stage, input logic [7:0] idx);
        return (stage == STAGE_MAIN) ? flag_main(idx) : flag_clean(idx);
    endfunction

endpackage

/* sv/bthp_front.sv */
// ============================================================================
// Binary thinning pass front end
// Accepts pixels, tracks the raster position, reads and rewrites the two
// line stores and hands each pixel with its column to the queue.
// ============================================================================
module bthp_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [bthp_pkg::PIX_W-1:0]        i_pixel,
    input  logic [bthp_pkg::DIM_CFG_W-1:0]    i_frame_cols,
    input  logic [bthp_pkg::DIM_CFG_W-1:0]    i_frame_rows,
    input  logic [bthp_pkg::Q_CNT_W-1:0]      i_q_count,
    output logic                              o_stall,
    output logic                              o_push,
    output bthp_pkg::t_front_beat             o_beat,
    output bthp_pkg::t_front_stat             o_stat
);
    import bthp_pkg::*;

    localparam int AW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW_C   = $clog2(MAX_COLS + 1);
    localparam int CW_R   = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = (CW_C > CW_R) ? CW_C : CW_R;
    localparam int DIM_W  = (CNT_W > DIM_CFG_W) ? CNT_W : DIM_CFG_W;
    localparam int MEM_W  = 2 * PIX_W;

    // Line stores: upper row in the high half, middle row in the low half.
    logic [MEM_W-1:0] r_mem [MAX_COLS];

    logic [AW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             r_f1_valid;
    logic [AW-1:0]    r_f1_addr;
    logic [PIX_W-1:0] r_f1_px;
    t_pos             r_f1_pos;
    logic [MEM_W-1:0] r_rd_data;

    logic [DIM_W-1:0] cols, rows, fc, fr, col_x, row_t, c, r, nc, nr;
    logic             wrap_c, accept;
    logic [AW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    t_pos             pos;
    logic [Q_CNT_W:0] in_flight;

    // Clamp the frame size to the legal range.
    always_comb begin
        fc = DIM_W'(i_frame_cols);
        fr = DIM_W'(i_frame_rows);
        if (fc < DIM_W'(DIM_MIN)) begin
            cols = DIM_W'(DIM_MIN);
        end else if (fc > DIM_W'(MAX_COLS)) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = fc;
        end
        if (fr < DIM_W'(DIM_MIN)) begin
            rows = DIM_W'(DIM_MIN);
        end else if (fr > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = fr;
        end
    end

    // Position of the arriving pixel and of the one after it.
    always_comb begin
        col_x  = DIM_W'(r_col);
        wrap_c = (col_x >= cols);
        c      = wrap_c ? '0 : col_x;
        row_t  = wrap_c ? DIM_W'(r_row) + DIM_W'(1) : DIM_W'(r_row);
        r      = (row_t >= rows) ? '0 : row_t;

        pos.emit  = (r >= DIM_W'(FIRST_INTERIOR)) && (c >= DIM_W'(FIRST_INTERIOR));
        pos.last  = (r == rows - DIM_W'(1)) && (c == cols - DIM_W'(1));
        pos.first = (c == '0) && (r == '0);

        nc = c + DIM_W'(1);
        nr = r + DIM_W'(1);
        if (nc >= cols) begin
            n_col = '0;
            n_row = (nr >= rows) ? '0 : nr[RW-1:0];
        end else begin
            n_col = nc[AW-1:0];
            n_row = r[RW-1:0];
        end
    end

    // Hold off the source while clearing or while the queue could overflow.
    always_comb begin
        in_flight = (Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_f1_valid);
        o_stall   = r_clr_busy || (in_flight >= (Q_CNT_W + 1)'(Q_DEPTH));
        accept    = i_valid && !o_stall;
    end

    // Raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Clearing sweep over the line stores after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(MAX_COLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Second front stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
        end
    end

    // Line store read and second stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[c[AW-1:0]];
            r_f1_addr <= c[AW-1:0];
            r_f1_px   <= i_pixel;
            r_f1_pos  <= pos;
        end
    end

    // Line store write: middle moves up, the new pixel becomes the middle.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_f1_valid) begin
            r_mem[r_f1_addr] <= {r_rd_data[PIX_W-1:0], r_f1_px};
        end
    end

    // Beat toward the queue.
    always_comb begin
        o_push          = r_f1_valid;
        o_beat.up       = r_rd_data[MEM_W-1:PIX_W];
        o_beat.mid      = r_rd_data[PIX_W-1:0];
        o_beat.px       = r_f1_px;
        o_beat.pos      = r_f1_pos;
        o_stat.clr_busy = r_clr_busy;
        o_stat.f1_valid = r_f1_valid;
    end

endmodule

/* sv/bthp_queue.sv */
// ============================================================================
// Binary thinning pass queue
// Short first-in first-out buffer of column beats between the front end and
// the back end.
// ============================================================================
module bthp_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  bthp_pkg::t_front_beat         i_beat,
    input  logic                          i_pop,
    output logic                          o_head_valid,
    output bthp_pkg::t_front_beat         o_head,
    output logic [bthp_pkg::Q_CNT_W-1:0]  o_count
);
    import bthp_pkg::*;

    t_front_beat        r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_beat;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];
    assign o_count      = r_count;

endmodule

/* sv/bthp_back.sv */
// ============================================================================
// Binary thinning pass back end
// Shifts each column into the 3x3 window, looks up the removal flag, keeps
// the removal tally and holds the result in the output register.
// ============================================================================
module bthp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  bthp_pkg::t_front_beat           i_head,
    input  logic [bthp_pkg::PIX_W-1:0]      i_bg_color,
    input  logic                            i_stage_select,
    input  logic                            i_pass_parity,
    input  logic                            i_stall,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [bthp_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                            o_removed,
    output logic                            o_frame_end,
    output logic [bthp_pkg::TALLY_W-1:0]    o_removed_count
);
    import bthp_pkg::*;

    // Right two window columns; bits 2:0 middle column, bits 5:3 right.
    logic [5:0]         r_win;
    logic [PIX_W-1:0]   r_prev_mid;
    logic [TALLY_W-1:0] r_tally;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel;
    logic               r_out_removed;
    logic               r_out_frame_end;
    logic [TALLY_W-1:0] r_out_count;

    logic [2:0]         col3;
    logic [8:0]         w;
    logic [7:0]         idx;
    logic [1:0]         flag, mask;
    logic               centre_fg, rem;
    logic [TALLY_W-1:0] n_tally;
    logic [PIX_W-1:0]   n_pixel;

    assign o_pop = i_head_valid && (!r_out_valid || !i_stall);

    // New window column, neighborhood index and removal decision.
    always_comb begin
        col3[0] = (i_head.up  != i_bg_color);
        col3[1] = (i_head.mid != i_bg_color);
        col3[2] = (i_head.px  != i_bg_color);
        w       = {col3, r_win};

        // Window bit to neighbor: 0 upper-left, 1 left, 2 lower-left, 3 up,
        // 5 down, 6 upper-right, 7 right, 8 lower-right; 4 is the centre.
        idx[0] = w[0];
        idx[1] = w[3];
        idx[2] = w[6];
        idx[3] = w[7];
        idx[4] = w[8];
        idx[5] = w[5];
        idx[6] = w[2];
        idx[7] = w[1];

        // Only an interior centre can be removed and counted.
        centre_fg = w[4];
        flag      = flag_lookup(i_stage_select, idx);
        mask      = i_pass_parity ? FLAG_PASS1 : FLAG_PASS0;
        rem       = i_head.pos.emit && centre_fg && ((flag & mask) != FLAG_NONE);
        n_tally   = (i_head.pos.first ? '0 : r_tally) + TALLY_W'(rem);
        n_pixel   = (rem || !centre_fg) ? i_bg_color : r_prev_mid;
    end

    // Window, centre value and tally advance on every beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_prev_mid <= '0;
            r_tally    <= '0;
        end else if (o_pop) begin
            r_win      <= w[8:3];
            r_prev_mid <= i_head.mid;
            r_tally    <= n_tally;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= i_head.pos.emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.pos.emit) begin
            r_out_pixel     <= n_pixel;
            r_out_removed   <= rem;
            r_out_frame_end <= i_head.pos.last;
            r_out_count     <= n_tally;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_out     = r_out_pixel;
    assign o_removed       = r_out_removed;
    assign o_frame_end     = r_out_frame_end;
    assign o_removed_count = r_out_count;

endmodule

/* sv/binary_thinning_pass.sv */
// ============================================================================
// Binary thinning pass
// One lookup-table thinning pass over a padded raster frame, one result per
// interior pixel with a running count of removed pixels.
// ============================================================================
//
//  Channel   Direction  Handshake           Beat contents
//  -------   ---------  ------------------  ---------------------------------
//  pixel     in         i_valid / o_stall   i_pixel_in
//  result    out        o_valid / i_stall   o_pixel_out, o_removed,
//                                           o_frame_end, o_removed_count
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
//  One pixel per clock is taken while o_stall is low and one result per
//  clock is given while i_stall is low, one for each interior pixel.
//  The line store read for the pixel that completes a window is registered,
//  then enters the queue; the window shift, flag lookup and output register
//  load happen as that beat is popped. After reset a sweep clears the MAX_COLS
//  line store entries, one entry per cycle; o_stall stays high until it ends.
//  A stalled result is held in the output register while the four-entry
//  queue keeps taking pixels until it is full.
//
module binary_thinning_pass #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bthp_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bthp_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_removed,
    output logic                              o_frame_end,
    output logic [bthp_pkg::TALLY_W-1:0]      o_removed_count,
    input  logic                              i_cfg_we,
    input  logic [bthp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bthp_pkg::CFG_W-1:0]        i_cfg_data
);
    import bthp_pkg::*;

    `include "binary_thinning_pass_defines.svh"

    logic [PIX_W-1:0]     r_bg_color;
    logic [DIM_CFG_W-1:0] r_frame_cols;
    logic [DIM_CFG_W-1:0] r_frame_rows;
    logic                 r_stage_select;
    logic                 r_pass_parity;

    logic                 push, pop, head_valid;
    t_front_beat          beat, head;
    t_front_stat          front_stat;
    logic [Q_CNT_W-1:0]   q_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_color     <= '0;
            r_frame_cols   <= DIM_CFG_W'(1024);
            r_frame_rows   <= DIM_CFG_W'(1024);
            r_stage_select <= STAGE_MAIN;
            r_pass_parity  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BG_COLOR:     r_bg_color     <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_COLS:   r_frame_cols   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_FRAME_ROWS:   r_frame_rows   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_STAGE_SELECT: r_stage_select <= i_cfg_data[0];
                CFG_PASS_PARITY:  r_pass_parity  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Position tracking and line stores.
    bthp_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_pixel      (i_pixel_in),
        .i_frame_cols (r_frame_cols),
        .i_frame_rows (r_frame_rows),
        .i_q_count    (q_count),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_beat       (beat),
        .o_stat       (front_stat)
    );

    // Decoupling queue.
    bthp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_beat       (beat),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    // Window, flag lookup and result register.
    bthp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .i_bg_color      (r_bg_color),
        .i_stage_select  (r_stage_select),
        .i_pass_parity   (r_pass_parity),
        .i_stall         (i_stall),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_pixel_out     (o_pixel_out),
        .o_removed       (o_removed),
        .o_frame_end     (o_frame_end),
        .o_removed_count (o_removed_count)
    );

    // No pixel enters while the line stores are being cleared.
    `BTHP_ASSERT_IMPLY(a_clear_blocks_input, front_stat.clr_busy, o_stall, "pixel taken during clear")
    // A beat leaving the line store stage always finds a free queue slot.
    `BTHP_ASSERT_IMPLY(a_push_has_room, front_stat.f1_valid, q_count < Q_CNT_W'(Q_DEPTH), "queue full on push")
    // The back end never pops an empty queue.
    `BTHP_ASSERT_IMPLY(a_pop_not_empty, pop, q_count != '0, "pop from empty queue")
    // The fill level never passes the queue depth.
    `BTHP_ASSERT_ALWAYS(a_count_bound, q_count <= Q_CNT_W'(Q_DEPTH), "queue count overflow")

endmodule
